// ----- design/disk_drive_port_with_timer_irq_macros.svh -----
// ----------------------------------------------------------------------------
// Disk drive port assertion macros
// Clocked assertion wrappers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef DISK_DRIVE_PORT_WITH_TIMER_IRQ_MACROS_SVH
`define DISK_DRIVE_PORT_WITH_TIMER_IRQ_MACROS_SVH

`ifndef SYNTHESIS
// Assertion that is checked only outside reset
`define DSK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("disk port assertion failed");
// Assertion that is checked during reset as well
`define DSK_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("disk port assertion failed");
`else
`define DSK_ASSERT(lbl, clk, rst, prop)
`define DSK_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- design/dsk_pkg.sv -----
// ----------------------------------------------------------------------------
// dsk_pkg
// Shared types and constants of the disk drive port with timer IRQ.
// ----------------------------------------------------------------------------
package dsk_pkg;

   localparam int DSK_DISK_BYTES = 65536;
   localparam int POS_W          = 17;
   localparam int CSR_W          = 17;

   // configuration register indexes
   localparam logic CSR_DISK_LENGTH  = 1'b0;
   localparam logic CSR_DISK_PRESENT = 1'b1;

   // transaction kinds
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;
   localparam logic [1:0] CMD_LOAD  = 2'd3;

   // register offsets from the first port register
   localparam logic [4:0] OFF_LATCH_LO = 5'd0;
   localparam logic [4:0] OFF_LATCH_HI = 5'd1;
   localparam logic [4:0] OFF_TIMER_EN = 5'd2;
   localparam logic [4:0] OFF_IO_EN    = 5'd3;
   localparam logic [4:0] OFF_WDATA    = 5'd4;
   localparam logic [4:0] OFF_CONTROL  = 5'd5;
   localparam logic [4:0] OFF_STATUS   = 5'd16;
   localparam logic [4:0] OFF_RDATA    = 5'd17;
   localparam logic [4:0] OFF_DRIVE    = 5'd18;
   localparam logic [4:0] OFF_CONST    = 5'd19;

   localparam logic [7:0] CONST_READ = 8'h80;

   // control bit positions
   localparam int CB_RESET  = 0;
   localparam int CB_MIRROR = 1;
   localparam int CB_WMODE  = 2;
   localparam int CB_MOTOR  = 3;
   localparam int CB_AVAIL  = 4;

   // control write data bits
   localparam int CW_RESET  = 0;
   localparam int CW_MIRROR = 1;
   localparam int CW_WMODE  = 2;
   localparam int CW_MOTOR  = 5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [4:0]  reg_offset;
      logic [7:0]  write_byte;
      logic [15:0] load_index;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       irq_line;
      logic       mirror_horiz;
   } rsp_type;

   // per-transaction result from the control logic to the output stage
   typedef struct packed {
      logic [7:0] rd_byte;
      logic       rd_mem;
      logic       irq;
      logic       mirror;
   } ctrl_out_type;

endpackage

// ----- design/dsk_store.sv -----
// ----------------------------------------------------------------------------
// dsk_store
// Disk image store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dsk_store
   import dsk_pkg::*;
#(
   parameter int DISK_BYTES = DSK_DISK_BYTES,
   parameter int ADDR_W     = $clog2(DSK_DISK_BYTES)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [7:0]        wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [7:0]        rdata
);

   logic [7:0] mem [DISK_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds while no new read is issued
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/dsk_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsk_ctrl
// Port registers, timer and disk positions; issues store accesses.
// ----------------------------------------------------------------------------
`include "disk_drive_port_with_timer_irq_macros.svh"

module dsk_ctrl
   import dsk_pkg::*;
#(
   parameter int DISK_BYTES = DSK_DISK_BYTES,
   parameter int ADDR_W     = $clog2(DSK_DISK_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  logic              accept,
   input  req_type           req,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [7:0]        mem_wdata,
   output logic              mem_re,
   output logic [ADDR_W-1:0] mem_raddr,
   output ctrl_out_type      result
);

   localparam int SZ_RAW = $clog2(DISK_BYTES + 1);
   localparam int SZ_W   = (SZ_RAW > POS_W) ? SZ_RAW : POS_W;
   localparam int XW     = (ADDR_W > POS_W) ? ADDR_W : POS_W;

   logic [POS_W-1:0] disk_length_ff;
   logic             disk_present_ff;
   logic [15:0]      timer_reload_ff, timer_reload_in;
   logic [15:0]      timer_count_ff, timer_count_in;
   logic             timer_on_ff, timer_on_in;
   logic             irq_ff, irq_in;
   logic             disk_io_ff, disk_io_in;
   logic             timer_io_ff, timer_io_in;
   logic [POS_W-1:0] rd_pos_ff, rd_pos_in;
   logic [POS_W-1:0] wr_pos_ff, wr_pos_in;
   logic [4:0]       ctrl_bits_ff, ctrl_bits_in;

   logic [SZ_W-1:0]  len_x, size_w;
   logic [POS_W-1:0] rd_pos_inc;
   logic             rd_lt, wr_lt, rd_inc_lt, size_nz;
   logic [XW-1:0]    rd_x, wr_x, li_x;
   logic             li_ok;
   logic [4:0]       cb;
   logic [7:0]       rd_byte;
   logic             rd_mem;

   // effective disk size: smaller of the programmed length and the store
   assign len_x      = SZ_W'(disk_length_ff);
   assign size_w     = (len_x < SZ_W'(DISK_BYTES)) ? len_x : SZ_W'(DISK_BYTES);
   assign size_nz    = (size_w != '0);
   assign rd_pos_inc = rd_pos_ff + POS_W'(1);
   assign rd_lt      = (SZ_W'(rd_pos_ff) < size_w);
   assign wr_lt      = (SZ_W'(wr_pos_ff) < size_w);
   assign rd_inc_lt  = (SZ_W'(rd_pos_inc) < size_w);
   assign li_ok      = (SZ_W'(req.load_index) < SZ_W'(DISK_BYTES));
   assign rd_x       = XW'(rd_pos_ff);
   assign wr_x       = XW'(wr_pos_ff);
   assign li_x       = XW'(req.load_index);

   always_comb begin
      timer_reload_in = timer_reload_ff;
      timer_count_in  = timer_count_ff;
      timer_on_in     = timer_on_ff;
      irq_in          = irq_ff;
      disk_io_in      = disk_io_ff;
      timer_io_in     = timer_io_ff;
      rd_pos_in       = rd_pos_ff;
      wr_pos_in       = wr_pos_ff;
      ctrl_bits_in    = ctrl_bits_ff;
      cb              = ctrl_bits_ff;
      rd_byte         = 8'h00;
      rd_mem          = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = wr_x[ADDR_W-1:0];
      mem_wdata       = req.write_byte;
      mem_re          = 1'b0;
      mem_raddr       = rd_x[ADDR_W-1:0];

      if (accept) begin
         unique case (req.cmd)
            CMD_READ: begin
               case (req.reg_offset)
                  OFF_STATUS: begin
                     rd_byte = {irq_ff, 2'b00, ctrl_bits_ff[CB_RESET], 1'b0,
                                ctrl_bits_ff[CB_MOTOR] & disk_present_ff, 1'b0,
                                ctrl_bits_ff[CB_AVAIL]};
                     irq_in  = 1'b0;
                  end
                  OFF_RDATA: begin
                     if (rd_lt) begin
                        rd_mem                 = 1'b1;
                        mem_re                 = 1'b1;
                        rd_pos_in              = rd_pos_inc;
                        ctrl_bits_in[CB_AVAIL] = rd_inc_lt;
                     end
                  end
                  OFF_DRIVE: rd_byte = {7'd0, ~disk_present_ff};
                  OFF_CONST: rd_byte = CONST_READ;
                  default:   rd_byte = 8'h00;
               endcase
            end
            CMD_WRITE: begin
               case (req.reg_offset)
                  OFF_LATCH_LO: timer_reload_in[7:0]  = req.write_byte;
                  OFF_LATCH_HI: timer_reload_in[15:8] = req.write_byte;
                  OFF_TIMER_EN: begin
                     timer_on_in = req.write_byte[0];
                     if (req.write_byte[0]) begin
                        timer_count_in = timer_reload_ff;
                     end else begin
                        irq_in = 1'b0;
                     end
                  end
                  OFF_IO_EN: begin
                     disk_io_in  = req.write_byte[0];
                     timer_io_in = req.write_byte[1];
                     if (!req.write_byte[1]) begin
                        irq_in = 1'b0;
                     end
                  end
                  OFF_WDATA: begin
                     if (ctrl_bits_ff[CB_WMODE] && disk_io_ff && wr_lt) begin
                        mem_we    = 1'b1;
                        wr_pos_in = wr_pos_ff + POS_W'(1);
                     end
                  end
                  OFF_CONTROL: begin
                     if (disk_io_ff) begin
                        // rising transfer reset rewinds both positions
                        if (req.write_byte[CW_RESET] && !ctrl_bits_ff[CB_RESET]) begin
                           rd_pos_in    = '0;
                           wr_pos_in    = '0;
                           cb[CB_AVAIL] = 1'b0;
                        end
                        cb[CB_RESET]  = req.write_byte[CW_RESET];
                        cb[CB_MIRROR] = req.write_byte[CW_MIRROR];
                        cb[CB_WMODE]  = req.write_byte[CW_WMODE];
                        cb[CB_MOTOR]  = req.write_byte[CW_MOTOR];
                        if (cb[CB_MOTOR] && !cb[CB_WMODE]) begin
                           cb[CB_AVAIL] = (req.write_byte[CW_RESET] &&
                                           !ctrl_bits_ff[CB_RESET]) ? size_nz : rd_lt;
                        end
                        ctrl_bits_in = cb;
                     end
                  end
                  default: ;
               endcase
            end
            CMD_TICK: begin
               if (timer_on_ff && timer_io_ff) begin
                  if (timer_count_ff == 16'd0) begin
                     timer_count_in = timer_reload_ff;
                     irq_in         = 1'b1;
                  end else begin
                     timer_count_in = timer_count_ff - 16'd1;
                  end
               end
            end
            CMD_LOAD: begin
               mem_waddr = li_x[ADDR_W-1:0];
               if (li_ok) begin
                  mem_we = 1'b1;
               end
            end
         endcase
      end
   end

   assign result.rd_byte = rd_byte;
   assign result.rd_mem  = rd_mem;
   assign result.irq     = irq_in;
   assign result.mirror  = ctrl_bits_in[CB_MIRROR];

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_length_ff  <= '0;
         disk_present_ff <= 1'b1;
         timer_reload_ff <= '0;
         timer_count_ff  <= '0;
         timer_on_ff     <= 1'b0;
         irq_ff          <= 1'b0;
         disk_io_ff      <= 1'b1;
         timer_io_ff     <= 1'b1;
         rd_pos_ff       <= '0;
         wr_pos_ff       <= '0;
         ctrl_bits_ff    <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_DISK_LENGTH) begin
               disk_length_ff <= csr_wdata;
            end else begin
               disk_present_ff <= csr_wdata[0];
            end
         end
         timer_reload_ff <= timer_reload_in;
         timer_count_ff  <= timer_count_in;
         timer_on_ff     <= timer_on_in;
         irq_ff          <= irq_in;
         disk_io_ff      <= disk_io_in;
         timer_io_ff     <= timer_io_in;
         rd_pos_ff       <= rd_pos_in;
         wr_pos_ff       <= wr_pos_in;
         ctrl_bits_ff    <= ctrl_bits_in;
      end
   end

   // one store port use per transaction
   `DSK_ASSERT_ALWAYS(a_one_mem_access, clock, !(mem_we && mem_re))
   // a running timer that is not at zero counts down by one per tick
   `DSK_ASSERT(a_tick_decrement, clock, reset,
      (accept && req.cmd == CMD_TICK && timer_on_ff && timer_io_ff &&
       timer_count_ff != 16'd0) |=> (timer_count_ff == $past(timer_count_ff) - 16'd1))

endmodule

// ----- design/disk_drive_port_with_timer_irq.sv -----
// ----------------------------------------------------------------------------
// disk_drive_port_with_timer_irq
// Register-mapped disk drive port with a reload timer interrupt.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transaction per item (bus read, bus write, CPU tick or
//    disk image load byte). Accepted when req_valid is high and req_stall low.
//  - rsp channel: exactly one transaction per request, in order, carrying the
//    read data, the interrupt line and the mirroring select after the item.
//  - csr port: disk_length (index 0) and disk_present (index 1), written
//    on csr_we; only change them while the port is idle.
//  - The response is registered: it appears in the cycle after acceptance.
//  - Throughput: one request per clock while req_stall is low. The limit is
//    the port register update plus one access of the disk store per request.
//  - Disk data reads use the store's registered read port; the byte lands in
//    the read data register on the same edge the response is loaded.
//  - A single output register decouples the sides; req_stall is raised only
//    while that register is full and rsp_stall is high, so a stalled
//    response holds and requests keep flowing as soon as it drains.
//  - Reset (synchronous, active high) restores all port registers and
//    empties the output register; the disk store is not cleared and must be
//    loaded before it is read.
// ----------------------------------------------------------------------------
`include "disk_drive_port_with_timer_irq_macros.svh"

module disk_drive_port_with_timer_irq
   import dsk_pkg::*;
#(
   parameter int DISK_BYTES = DSK_DISK_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   // configuration
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   // requests
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   // responses
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam int ADDR_W = $clog2(DISK_BYTES);

   logic              accept;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata, mem_rdata;
   ctrl_out_type      ctrl_result;

   logic              rsp_valid_ff, rsp_valid_in;
   ctrl_out_type      rsp_info_ff;

   // output register full and held by the receiver
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   dsk_ctrl #(
      .DISK_BYTES (DISK_BYTES),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req       (req_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .result    (ctrl_result)
   );

   dsk_store #(
      .DISK_BYTES (DISK_BYTES),
      .ADDR_W     (ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // output stage: load on accept, empty when taken and nothing new arrives
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_info_ff <= ctrl_result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.read_byte    = rsp_info_ff.rd_mem ? mem_rdata : rsp_info_ff.rd_byte;
   assign rsp_data.irq_line     = rsp_info_ff.irq;
   assign rsp_data.mirror_horiz = rsp_info_ff.mirror;

   // every accepted request yields a response in the next cycle
   `DSK_ASSERT(a_accept_to_rsp, clock, reset, accept |=> rsp_valid_ff)
   // disk read data must survive a stalled response
   `DSK_ASSERT(a_rdata_hold, clock, reset,
      (rsp_valid_ff && rsp_stall && rsp_info_ff.rd_mem) |=> $stable(mem_rdata))
   // a disk data response only follows a disk data read
   `DSK_ASSERT(a_rd_mem_src, clock, reset,
      (accept && ctrl_result.rd_mem) |-> (req_data.cmd == CMD_READ &&
                                          req_data.reg_offset == OFF_RDATA))

endmodule
